// ===== sv/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsvrgb_pkg;

  // Full scale of an 8-bit channel
  localparam logic [7:0] ChanMax = 8'd255;
  // 255 in the top byte of a 24-bit word, i.e. 255 * 65536
  localparam logic [23:0] FracDen = 24'hFF0000;

  // Hue sector: which sixth of the turn the pixel lies in
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Products handed from the front stages to the level stages
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [23:0] sf;    // saturation * fraction
    logic [15:0] vps;   // value * (255 - saturation)
  } mid_t;

  // Floor of x / 255 for x up to 255 * 255: estimate by x / 256, then
  // correct once from the remainder, which stays below 2 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [7:0] est;
    logic [8:0] rem;
    est = x[15:8];
    rem = {1'b0, x[7:0]} + {1'b0, est};
    if (rem >= 9'd255) begin
      return est + 8'd1;
    end else begin
      return est;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/hsvrgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSV pixel channel
interface hsvrgb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// RGB pixel channel
interface hsvrgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== sv/hsvrgb_prod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 1 and 2: split the hue into sector and fraction, then form the products
module hsvrgb_prod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output      logic              up_ready,
  input  wire logic [15:0]       hue,
  input  wire logic [7:0]        sat,
  input  wire logic [7:0]        val,
  output      logic              dn_valid,
  input  wire logic              dn_ready,
  output      hsvrgb_pkg::mid_t  dn_data
);

  logic                 v1_r, v1_nxt;
  logic                 v2_r, v2_nxt;
  logic                 en1, en2;
  logic [18:0]          scaled;
  hsvrgb_pkg::sector_t  sector1_r;
  logic [15:0]          frac1_r;
  logic [7:0]           sat1_r, val1_r;
  hsvrgb_pkg::mid_t     mid_nxt, mid_r;

  // Advance a stage when it is empty or its successor moves
  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign v1_nxt = en1 ? up_valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Hue times six as shift and add; top bits are the sector
  assign scaled = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  always_ff @(posedge clk) begin
    if (en1) begin
      sector1_r <= hsvrgb_pkg::sector_t'(scaled[18:16]);
      frac1_r   <= scaled[15:0];
      sat1_r    <= sat;
      val1_r    <= val;
    end
  end

  // Two products: saturation by fraction, value by complement of saturation
  always_comb begin
    mid_nxt        = '0;
    mid_nxt.sector = sector1_r;
    mid_nxt.sat    = sat1_r;
    mid_nxt.val    = val1_r;
    mid_nxt.sf     = {8'd0, frac1_r} * {16'd0, sat1_r};
    mid_nxt.vps    = {8'd0, val1_r} * {8'd0, hsvrgb_pkg::ChanMax - sat1_r};
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mid_r <= mid_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = mid_r;

endmodule

`default_nettype wire

// ===== sv/hsvrgb_level.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages 3 and 4: scale by value, divide by full scale, route to channels
module hsvrgb_level (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output      logic              up_ready,
  input  wire hsvrgb_pkg::mid_t  up_data,
  output      logic              dn_valid,
  input  wire logic              dn_ready,
  output      logic [7:0]        red,
  output      logic [7:0]        green,
  output      logic [7:0]        blue
);

  logic                 v3_r, v3_nxt;
  logic                 v4_r, v4_nxt;
  logic                 en3, en4;
  logic [23:0]          q_term, t_term;
  logic [31:0]          q_prod, t_prod;
  hsvrgb_pkg::sector_t  sector3_r;
  logic [7:0]           val3_r, p3_r;
  logic [15:0]          qn3_r, tn3_r;
  logic [7:0]           q_lvl, t_lvl;
  logic [7:0]           red_nxt, green_nxt, blue_nxt;
  logic [7:0]           red_r, green_r, blue_r;

  // Advance a stage when it is empty or its successor moves
  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;

  assign v3_nxt = en3 ? up_valid : v3_r;
  assign v4_nxt = en4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Numerators over 255 * 65536; the t term rewritten as
  // (255 - s) * 65536 + s * f so both share one product
  assign q_term = hsvrgb_pkg::FracDen - up_data.sf;
  assign t_term = {hsvrgb_pkg::ChanMax - up_data.sat, 16'd0} + up_data.sf;
  assign q_prod = {24'd0, up_data.val} * {8'd0, q_term};
  assign t_prod = {24'd0, up_data.val} * {8'd0, t_term};

  // Drop the low 16 bits now; the divide by 255 follows next stage
  always_ff @(posedge clk) begin
    if (en3) begin
      sector3_r <= up_data.sector;
      val3_r    <= up_data.val;
      p3_r      <= hsvrgb_pkg::div255(up_data.vps);
      qn3_r     <= q_prod[31:16];
      tn3_r     <= t_prod[31:16];
    end
  end

  assign q_lvl = hsvrgb_pkg::div255(qn3_r);
  assign t_lvl = hsvrgb_pkg::div255(tn3_r);

  // Route levels by sector
  always_comb begin
    unique case (sector3_r)
      hsvrgb_pkg::SEC_RED: begin
        red_nxt = val3_r; green_nxt = t_lvl;  blue_nxt = p3_r;
      end
      hsvrgb_pkg::SEC_YELLOW: begin
        red_nxt = q_lvl;  green_nxt = val3_r; blue_nxt = p3_r;
      end
      hsvrgb_pkg::SEC_GREEN: begin
        red_nxt = p3_r;   green_nxt = val3_r; blue_nxt = t_lvl;
      end
      hsvrgb_pkg::SEC_CYAN: begin
        red_nxt = p3_r;   green_nxt = q_lvl;  blue_nxt = val3_r;
      end
      hsvrgb_pkg::SEC_BLUE: begin
        red_nxt = t_lvl;  green_nxt = p3_r;   blue_nxt = val3_r;
      end
      default: begin
        red_nxt = val3_r; green_nxt = p3_r;   blue_nxt = q_lvl;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB pixel converter. Takes one pixel per clock and returns one per
// clock when the output is not held back. A pixel passes through four
// register stages: hue split, the saturation and value products, the value
// scaling with its 8x24 multipliers, and the divide by 255 with channel
// routing into the output register. Each stage moves on its own, so a held
// output still lets new pixels fill any empty stage behind it.
// Hue is a fraction of a turn in units of 1/65536; saturation and value are
// 8-bit with 255 as full scale; zero saturation yields grey.
module hsv_to_rgb_convert (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsvrgb_in_if.sink    in_px,
  hsvrgb_out_if.source out_px
);

  logic              mid_valid;
  logic              mid_ready;
  hsvrgb_pkg::mid_t  mid_data;

  hsvrgb_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_px.valid),
    .up_ready (in_px.ready),
    .hue      (in_px.hue),
    .sat      (in_px.saturation),
    .val      (in_px.brightness),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  hsvrgb_level u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .dn_valid (out_px.valid),
    .dn_ready (out_px.ready),
    .red      (out_px.red),
    .green    (out_px.green),
    .blue     (out_px.blue)
  );

`ifndef SYNTH
  // No beat leaves straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_px.valid)
    else $error("output valid after reset");

  // A ready output frees every stage, so the input must be ready to take a beat
  a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.ready |-> in_px.ready)
    else $error("input stalled while output ready");

  // A held mid-pipeline beat keeps its contents
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mid_valid && !mid_ready |=> mid_valid && $stable(mid_data))
    else $error("mid-pipeline beat lost or changed while stalled");
`endif

endmodule

`default_nettype wire
